// File: sv/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types and constants for the key press classifier: register indexes,
// event codes, scan tick length and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package kpc_pkg;

   // scan tick length in ms and timing limits
   localparam logic [15:0] TICK_MS      = 16'd10;
   localparam logic [15:0] SHORT_MIN_MS = 16'd50;
   localparam logic [15:0] TIME_MAX     = 16'hFFFF;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIN_INVERT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIME_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIME_B = 2'd2;

   // event codes
   localparam logic [1:0] EV_SHORT  = 2'd0;
   localparam logic [1:0] EV_LONG_A = 2'd1;
   localparam logic [1:0] EV_LONG_B = 2'd2;

   typedef struct packed {
      logic        pin_invert;
      logic [15:0] long_time_a;
      logic [15:0] long_time_b;
   } kpc_cfg_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] kind;
   } kpc_event_type;

endpackage

`default_nettype wire

// File: sv/kpc_csr.sv
// ----------------------------------------------------------------------------
// kpc_csr
// Configuration register file: polarity and the two long-press thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_csr
   import kpc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata,
   output      kpc_cfg_type          cfg
);

   kpc_cfg_type cfg_ff;
   kpc_cfg_type cfg_in;

   // decode the write; an unknown index leaves everything as it is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PIN_INVERT:  cfg_in.pin_invert  = csr_wdata[0];
            CSR_LONG_TIME_A: cfg_in.long_time_a = csr_wdata;
            CSR_LONG_TIME_B: cfg_in.long_time_b = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: sv/kpc_core.sv
// ----------------------------------------------------------------------------
// kpc_core
// Key state (pressed flag, time in level) and the press classification for
// one scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_core
   import kpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  wire logic          pin_level,
   input  wire kpc_cfg_type   cfg,
   output kpc_event_type      evt
);

   logic        pressed_ff,    pressed_in;
   logic [15:0] level_time_ff, level_time_in;

   logic        now_p;
   logic [16:0] time_sum;
   logic [15:0] lo, hi;
   logic [1:0]  kind_lo, kind_hi;
   logic        released;
   logic        reach_hi, reach_short;
   logic        rel_lo_hi, rel_short_lo, rel_short_hi;

   // work out the new level and its time
   always_comb begin
      now_p    = pin_level ^ cfg.pin_invert;
      time_sum = {1'b0, level_time_ff} + {1'b0, TICK_MS};
      if (now_p != pressed_ff) begin
         level_time_in = '0;
      end else if (time_sum[16]) begin
         level_time_in = TIME_MAX;
      end else begin
         level_time_in = time_sum[15:0];
      end
      pressed_in = now_p;
   end

   // sort the thresholds; a equal to b counts a as the lower one
   always_comb begin
      if (cfg.long_time_b >= cfg.long_time_a) begin
         lo      = cfg.long_time_a;
         hi      = cfg.long_time_b;
         kind_lo = EV_LONG_A;
         kind_hi = EV_LONG_B;
      end else begin
         lo      = cfg.long_time_b;
         hi      = cfg.long_time_a;
         kind_lo = EV_LONG_B;
         kind_hi = EV_LONG_A;
      end
   end

   // threshold crossings while held, and release windows
   always_comb begin
      released     = pressed_ff && !now_p;
      reach_hi     = now_p && (level_time_in >= hi) && (level_time_ff < hi);
      reach_short  = now_p && (level_time_in >= SHORT_MIN_MS)
                     && (level_time_ff < SHORT_MIN_MS);
      rel_lo_hi    = released && (level_time_ff >= lo) && (level_time_ff < hi);
      rel_short_lo = released && (level_time_ff >= SHORT_MIN_MS)
                     && (level_time_ff < lo);
      rel_short_hi = released && (level_time_ff >= SHORT_MIN_MS)
                     && (level_time_ff < hi);
   end

   // pick the event; order of the rules decides
   always_comb begin
      evt = '0;
      priority if (hi != '0 && lo != '0) begin
         priority if (reach_hi) begin
            evt.hit  = 1'b1;
            evt.kind = kind_hi;
         end else if (rel_lo_hi) begin
            evt.hit  = 1'b1;
            evt.kind = kind_lo;
         end else if (rel_short_lo) begin
            evt.hit  = 1'b1;
            evt.kind = EV_SHORT;
         end else begin
            evt = '0;
         end
      end else if (hi != '0) begin
         priority if (reach_hi) begin
            evt.hit  = 1'b1;
            evt.kind = kind_hi;
         end else if (rel_short_hi) begin
            evt.hit  = 1'b1;
            evt.kind = EV_SHORT;
         end else begin
            evt = '0;
         end
      end else begin
         evt.hit  = reach_short;
         evt.kind = EV_SHORT;
      end
   end

   // advance the key state when the tick is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff    <= 1'b0;
         level_time_ff <= '0;
      end else if (fire) begin
         pressed_ff    <= pressed_in;
         level_time_ff <= level_time_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/key_press_classifier.sv
// Key press classifier: one request per scan tick, zero or one event each.
// Requests wait in the input register until the result slot is free.
// Throughput: one request per cycle unless rsp_stall holds a result; the
// registers let the classify logic between them run on every such cycle.
// Reset: synchronous, clears key state, thresholds, polarity and both stages.
// ----------------------------------------------------------------------------
// key_press_classifier
// Top level: request register, classification core, result register and
// the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_classifier
   import kpc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic                 req_pin_level,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [1:0]           rsp_event_kind,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata
);

   kpc_cfg_type   cfg;
   kpc_event_type evt;

   logic       in_valid_ff, in_valid_in;
   logic       in_pin_ff;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_kind_ff;
   logic       out_free;
   logic       fire;
   logic       req_take;

   assign csr_ready = 1'b1;

   kpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kpc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .pin_level (in_pin_ff),
      .cfg       (cfg),
      .evt       (evt)
   );

   // handshake: the held request moves on once the result slot is free
   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      fire      = in_valid_ff && out_free;
      req_stall = in_valid_ff && !out_free;
      req_take  = req_valid && !req_stall;
   end

   // hold or advance the request stage
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // load a new event, drop a taken one
   always_comb begin
      if (fire && evt.hit) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pin_ff <= req_pin_level;
      end
      if (fire && evt.hit) begin
         out_kind_ff <= evt.kind;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;

endmodule

`default_nettype wire
